// File: hdl/obfv_pkg.sv
// Shared constants for the orthonormal basis pipeline.
`default_nettype none
package obfv_pkg;
  localparam int MAG_W        = 30;   // magnitude width after range scaling
  localparam int NORM_TOP     = 29;   // leading one lands here
  localparam int SQ_W         = 62;   // sum of three squares
  localparam int ROOT_W       = 31;   // floor(sqrt) of the sum
  localparam int RW           = 32;   // divider remainder width
  localparam int SQRT_CELLS   = 31;
  localparam int SQRT_TOP_BIT = 60;
  localparam int OUT_W        = 16;
  localparam int OUT_FIELDS   = 9;
  localparam int OUT_DW       = OUT_W * OUT_FIELDS;
  localparam int CFG_W        = 15;
  localparam logic [CFG_W-1:0] THR_RESET = 15'd14746;
endpackage
`default_nettype wire

// File: hdl/obfv_sqrt_cell.sv
// One digit-by-digit square root step with a carried payload.
`default_nettype none
module obfv_sqrt_cell #(
  parameter int PW      = 1,
  parameter int BIT_POS = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [obfv_pkg::SQ_W-1:0]  in_rem,
  input  logic [obfv_pkg::SQ_W-1:0]  in_root,
  input  logic [PW-1:0]              in_pass,
  output logic                       out_vld,
  output logic [obfv_pkg::SQ_W-1:0]  out_rem,
  output logic [obfv_pkg::SQ_W-1:0]  out_root,
  output logic [PW-1:0]              out_pass
);
  import obfv_pkg::*;

  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            ge;
  logic [SQ_W-1:0] rem_r, rem_nxt, root_r, root_nxt;
  logic [PW-1:0]   pass_r;
  logic            vld_r;

  always_comb begin
    bitv     = SQ_W'(1) << BIT_POS;
    trial    = {1'b0, in_root} + {1'b0, bitv};
    ge       = {1'b0, in_rem} >= trial;
    rem_nxt  = ge ? (in_rem - SQ_W'(trial)) : in_rem;
    root_nxt = ge ? ((in_root >> 1) + bitv) : (in_root >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pass_r <= in_pass;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_pass = pass_r;
endmodule
`default_nettype wire

// File: hdl/obfv_div_cell.sv
// One restoring division step on three components sharing a divisor.
`default_nettype none
module obfv_div_cell #(
  parameter int PW = 1,
  parameter int QW = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [2:0][obfv_pkg::RW+QW-1:0]      in_acc,
  input  logic [obfv_pkg::ROOT_W-1:0]          in_len,
  input  logic [PW-1:0]                        in_pass,
  output logic                                 out_vld,
  output logic [2:0][obfv_pkg::RW+QW-1:0]      out_acc,
  output logic [obfv_pkg::ROOT_W-1:0]          out_len,
  output logic [PW-1:0]                        out_pass
);
  import obfv_pkg::*;
  localparam int AW = RW + QW;

  logic [2:0][AW-1:0] acc_r, acc_nxt;
  logic [ROOT_W-1:0]  len_r;
  logic [PW-1:0]      pass_r;
  logic               vld_r;
  logic [RW-1:0]      r2;
  logic               ge;

  always_comb begin
    acc_nxt = '0;
    r2      = '0;
    ge      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r2         = in_acc[i][AW-2:QW-1];
      ge         = r2 >= RW'(in_len);
      acc_nxt[i] = {(ge ? (r2 - RW'(in_len)) : r2), in_acc[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= acc_nxt;
      len_r  <= in_len;
      pass_r <= in_pass;
    end
  end

  assign out_vld  = vld_r;
  assign out_acc  = acc_r;
  assign out_len  = len_r;
  assign out_pass = pass_r;
endmodule
`default_nettype wire

// File: hdl/obfv_norm.sv
// Pipelined vector normaliser: range scale, square root chain, divider chain.
`default_nettype none
module obfv_norm #(
  parameter int MW        = 30,
  parameter int FRAC_BITS = 14,
  parameter int SW        = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [2:0][MW:0]            in_vec,
  input  logic [SW-1:0]               in_side,
  output logic                        out_vld,
  output logic [2:0][FRAC_BITS+1:0]   out_u,
  output logic                        out_zero,
  output logic [SW-1:0]               out_side
);
  import obfv_pkg::*;
  localparam int UW  = FRAC_BITS + 2;
  localparam int PSW = $clog2(MW);
  localparam int QW  = FRAC_BITS + 1;
  localparam int AW  = RW + QW;
  localparam int XW  = MW + MAG_W;
  localparam int SPW = 3 * MAG_W + 4 + SW;
  localparam int DPW = 4 + SW;
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  // stage a: magnitudes and leading one
  logic [2:0][MW-1:0] mag;
  logic [2:0]         neg;
  logic [MW-1:0]      orv;
  logic [PSW-1:0]     pos;
  logic [2:0][MW-1:0] mag_a_r;
  logic [2:0]         neg_a_r;
  logic [PSW-1:0]     pos_a_r;
  logic               zero_a_r, vld_a_r;
  logic [SW-1:0]      side_a_r;

  always_comb begin
    orv = '0;
    pos = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = in_vec[i][MW];
      mag[i] = MW'(neg[i] ? (~in_vec[i] + 1'b1) : in_vec[i]);
      orv    = orv | mag[i];
    end
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) pos = PSW'(b);
    end
  end

  // stage b: scale so the largest magnitude sits in [2^29, 2^30)
  logic [2:0][MAG_W-1:0] m_b_nxt, m_b_r;
  logic [2:0]            neg_b_r;
  logic                  zero_b_r, vld_b_r;
  logic [SW-1:0]         side_b_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_a_r >= PSW'(NORM_TOP))
        m_b_nxt[i] = MAG_W'(mag_a_r[i] >> (pos_a_r - PSW'(NORM_TOP)));
      else
        m_b_nxt[i] = MAG_W'(XW'(mag_a_r[i]) << (PSW'(NORM_TOP) - pos_a_r));
    end
  end

  // stage c: squares, stage d: sum
  logic [2:0][2*MAG_W-1:0] sq_nxt, sq_c_r;
  logic [2:0][MAG_W-1:0]   m_c_r, m_d_r;
  logic [2:0]              neg_c_r, neg_d_r;
  logic                    zero_c_r, zero_d_r, vld_c_r, vld_d_r;
  logic [SW-1:0]           side_c_r, side_d_r;
  logic [SQ_W-1:0]         sum_d_r;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_nxt[i] = m_b_r[i] * m_b_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag;
      neg_a_r  <= neg;
      pos_a_r  <= pos;
      zero_a_r <= (orv == '0);
      side_a_r <= in_side;
      m_b_r    <= m_b_nxt;
      neg_b_r  <= neg_a_r;
      zero_b_r <= zero_a_r;
      side_b_r <= side_a_r;
      sq_c_r   <= sq_nxt;
      m_c_r    <= m_b_r;
      neg_c_r  <= neg_b_r;
      zero_c_r <= zero_b_r;
      side_c_r <= side_b_r;
      sum_d_r  <= SQ_W'(sq_c_r[0]) + SQ_W'(sq_c_r[1]) + SQ_W'(sq_c_r[2]);
      m_d_r    <= m_c_r;
      neg_d_r  <= neg_c_r;
      zero_d_r <= zero_c_r;
      side_d_r <= side_c_r;
    end
  end

  // square root chain, two bits of the radicand per cell
  logic [SQ_W-1:0] rem_c  [SQRT_CELLS+1];
  logic [SQ_W-1:0] root_c [SQRT_CELLS+1];
  logic [SPW-1:0]  spass_c[SQRT_CELLS+1];
  logic            svld_c [SQRT_CELLS+1];

  assign rem_c[0]   = sum_d_r;
  assign root_c[0]  = '0;
  assign spass_c[0] = {side_d_r, zero_d_r, neg_d_r, m_d_r};
  assign svld_c[0]  = vld_d_r;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    obfv_sqrt_cell #(.PW(SPW), .BIT_POS(SQRT_TOP_BIT - 2 * k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (svld_c[k]),
      .in_rem  (rem_c[k]),
      .in_root (root_c[k]),
      .in_pass (spass_c[k]),
      .out_vld (svld_c[k+1]),
      .out_rem (rem_c[k+1]),
      .out_root(root_c[k+1]),
      .out_pass(spass_c[k+1])
    );
  end

  // stage e: dividend = (m << FRAC_BITS) + len/2
  logic [ROOT_W-1:0]     len_s;
  logic [2:0][MAG_W-1:0] m_s;
  logic [DPW-1:0]        dpass_s;
  logic [2:0][AW-1:0]    acc_e_nxt, acc_e_r;
  logic [ROOT_W-1:0]     len_e_r;
  logic [DPW-1:0]        dpass_e_r;
  logic                  vld_e_r;

  assign len_s   = root_c[SQRT_CELLS][ROOT_W-1:0];
  assign m_s     = spass_c[SQRT_CELLS][3*MAG_W-1:0];
  assign dpass_s = spass_c[SQRT_CELLS][SPW-1:3*MAG_W];

  always_comb begin
    for (int i = 0; i < 3; i++)
      acc_e_nxt[i] = AW'({m_s[i], {FRAC_BITS{1'b0}}}) + AW'(len_s >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= svld_c[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_e_r   <= acc_e_nxt;
      len_e_r   <= len_s;
      dpass_e_r <= dpass_s;
    end
  end

  // divider chain, one quotient bit per cell
  logic [2:0][AW-1:0] acc_c  [QW+1];
  logic [ROOT_W-1:0]  len_c  [QW+1];
  logic [DPW-1:0]     dpass_c[QW+1];
  logic               dvld_c [QW+1];

  assign acc_c[0]   = acc_e_r;
  assign len_c[0]   = len_e_r;
  assign dpass_c[0] = dpass_e_r;
  assign dvld_c[0]  = vld_e_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    obfv_div_cell #(.PW(DPW), .QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (dvld_c[k]),
      .in_acc  (acc_c[k]),
      .in_len  (len_c[k]),
      .in_pass (dpass_c[k]),
      .out_vld (dvld_c[k+1]),
      .out_acc (acc_c[k+1]),
      .out_len (len_c[k+1]),
      .out_pass(dpass_c[k+1])
    );
  end

  // output: saturate, sign, zero vector
  logic [2:0]         neg_o;
  logic               zero_o;
  logic [QW-1:0]      q;
  logic [2:0][UW-1:0] u_nxt, u_r;
  logic               zero_r, vld_r;
  logic [SW-1:0]      side_r;

  assign neg_o  = dpass_c[QW][2:0];
  assign zero_o = dpass_c[QW][3];

  always_comb begin
    q     = '0;
    u_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      q = acc_c[QW][i][QW-1:0];
      if (q > ONE) q = ONE;
      if (zero_o)
        u_nxt[i] = '0;
      else if (neg_o[i])
        u_nxt[i] = ~UW'(q) + 1'b1;
      else
        u_nxt[i] = UW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= dvld_c[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      zero_r <= zero_o;
      side_r <= dpass_c[QW][DPW-1:4];
    end
  end

  assign out_vld  = vld_r;
  assign out_u    = u_r;
  assign out_zero = zero_r;
  assign out_side = side_r;
endmodule
`default_nettype wire

// File: hdl/orthonormal_basis_from_vector_top.sv
// Top level: orthonormal basis (Gram-Schmidt) from one direction vector.
// Throughput: one transaction per cycle while the skid entry is empty; every stage is a register, including the
//   31-cell square root chain and the FRAC_BITS+1 divider cells in each of three normalisers.
// A two-entry output buffer (output register plus skid) decouples in_tready from out_tready.
// Reset (rst_n low, synchronous) empties the pipeline and loads the threshold with 0.9 in Q1.14.
`default_nettype none
module orthonormal_basis_from_vector_top #(
  parameter int IN_WIDTH  = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [obfv_pkg::CFG_W-1:0]           cfg_wr_data, // axis_switch_threshold
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_x, in_y, in_z from bit 0 up, zero padded to bytes
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // first_x/y/z, second_x/y/z, third_x/y/z from bit 0 up, 16 bits each
  output logic [obfv_pkg::OUT_DW-1:0]          out_tdata,
  output logic                                 out_tuser    // degenerate
);
  import obfv_pkg::*;

  localparam int MW  = (IN_WIDTH > 2*FRAC_BITS+2) ? IN_WIDTH : 2*FRAC_BITS+2;
  localparam int VW  = MW + 1;
  localparam int UW  = FRAC_BITS + 2;
  localparam int PRW = 2 * UW;
  localparam int CW  = (FRAC_BITS + 1 > CFG_W) ? FRAC_BITS + 1 : CFG_W;
  localparam int EW  = (UW > OUT_W) ? UW : OUT_W;
  localparam int S2W = 1 + 3 * UW;
  localparam int S3W = 1 + 6 * UW;
  localparam logic signed [PRW-1:0] ONE2 = PRW'(1) << (2 * FRAC_BITS);

  // pipeline advances whenever the skid stage is free
  logic en;
  logic skid_vld_r, out_vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // threshold register
  logic [CFG_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // input stage
  logic [2:0][VW-1:0] v0_nxt, v0_r;
  logic               vld0_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      v0_nxt[i] = VW'($signed(in_tdata[i*IN_WIDTH +: IN_WIDTH]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) v0_r <= v0_nxt;
  end

  // first vector
  logic               n_vld, n_zero;
  logic [2:0][UW-1:0] n_u;

  obfv_norm #(.MW(MW), .FRAC_BITS(FRAC_BITS), .SW(1)) u_norm_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld0_r),
    .in_vec  (v0_r),
    .in_side (1'b0),
    .out_vld (n_vld),
    .out_u   (n_u),
    .out_zero(n_zero),
    .out_side()
  );

  // helper axis choice and projection products
  logic [UW-1:0]              n0_abs;
  logic                       sel;
  logic [UW-1:0]              dsel;
  logic [2:0][PRW-1:0]        p_nxt, p1_r;
  logic [2:0][UW-1:0]         n1_r;
  logic                       sel1_r, deg1_r, vld1_r;

  always_comb begin
    n0_abs = n_u[0][UW-1] ? (~n_u[0] + 1'b1) : n_u[0];
    sel    = CW'(n0_abs) > CW'(thr_r);
    dsel   = sel ? n_u[1] : n_u[0];
    for (int i = 0; i < 3; i++)
      p_nxt[i] = $signed(dsel) * $signed(n_u[i]);
  end

  // Gram-Schmidt remainder: helper minus its projection on the first vector
  logic [2:0][VW-1:0] w_nxt, w2_r;
  logic [2:0][UW-1:0] n2_r;
  logic               deg2_r, vld2_r;

  always_comb begin
    w_nxt[0] = VW'(sel1_r ? -$signed(p1_r[0]) : ONE2 - $signed(p1_r[0]));
    w_nxt[1] = VW'(sel1_r ? ONE2 - $signed(p1_r[1]) : -$signed(p1_r[1]));
    w_nxt[2] = VW'(-$signed(p1_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= n_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p_nxt;
      n1_r   <= n_u;
      sel1_r <= sel;
      deg1_r <= n_zero;
      w2_r   <= w_nxt;
      n2_r   <= n1_r;
      deg2_r <= deg1_r;
    end
  end

  // second vector
  logic               s_vld;
  logic [2:0][UW-1:0] s_u;
  logic [S2W-1:0]     s_side;

  obfv_norm #(.MW(MW), .FRAC_BITS(FRAC_BITS), .SW(S2W)) u_norm_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld2_r),
    .in_vec  (w2_r),
    .in_side ({deg2_r, n2_r}),
    .out_vld (s_vld),
    .out_u   (s_u),
    .out_zero(),
    .out_side(s_side)
  );

  // cross product first x second
  logic [2:0][UW-1:0]  ns;
  logic [5:0][PRW-1:0] x_nxt, x1_r;
  logic [2:0][UW-1:0]  nx1_r, sx1_r, nx2_r, sx2_r;
  logic                degx1_r, degx2_r, vldx1_r, vldx2_r;
  logic [2:0][VW-1:0]  c_nxt, c2_r;

  assign ns = s_side[3*UW-1:0];

  always_comb begin
    x_nxt[0] = $signed(ns[1]) * $signed(s_u[2]);
    x_nxt[1] = $signed(ns[2]) * $signed(s_u[1]);
    x_nxt[2] = $signed(ns[2]) * $signed(s_u[0]);
    x_nxt[3] = $signed(ns[0]) * $signed(s_u[2]);
    x_nxt[4] = $signed(ns[0]) * $signed(s_u[1]);
    x_nxt[5] = $signed(ns[1]) * $signed(s_u[0]);
    for (int i = 0; i < 3; i++)
      c_nxt[i] = VW'($signed(x1_r[2*i]) - $signed(x1_r[2*i+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldx1_r <= 1'b0;
      vldx2_r <= 1'b0;
    end else if (en) begin
      vldx1_r <= s_vld;
      vldx2_r <= vldx1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x_nxt;
      nx1_r   <= ns;
      sx1_r   <= s_u;
      degx1_r <= s_side[S2W-1];
      c2_r    <= c_nxt;
      nx2_r   <= nx1_r;
      sx2_r   <= sx1_r;
      degx2_r <= degx1_r;
    end
  end

  // third vector
  logic               t_vld;
  logic [2:0][UW-1:0] t_u;
  logic [S3W-1:0]     t_side;

  obfv_norm #(.MW(MW), .FRAC_BITS(FRAC_BITS), .SW(S3W)) u_norm_third (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vldx2_r),
    .in_vec  (c2_r),
    .in_side ({degx2_r, sx2_r, nx2_r}),
    .out_vld (t_vld),
    .out_u   (t_u),
    .out_zero(),
    .out_side(t_side)
  );

  // result packing; fields wrap to 16 bits, degenerate forces zeros
  logic [OUT_FIELDS-1:0][UW-1:0]    fld;
  logic [OUT_FIELDS-1:0][OUT_W-1:0] fld16;
  logic                             deg_t;
  logic [OUT_DW-1:0]                pd;
  logic signed [EW-1:0]             ext;

  assign deg_t = t_side[S3W-1];

  always_comb begin
    fld[2:0] = t_side[3*UW-1:0];
    fld[5:3] = t_side[6*UW-1:3*UW];
    fld[8:6] = t_u;
    ext      = '0;
    for (int f = 0; f < OUT_FIELDS; f++) begin
      ext      = EW'($signed(fld[f]));
      fld16[f] = deg_t ? '0 : ext[OUT_W-1:0];
    end
    pd = fld16;
  end

  // output register plus skid entry
  logic [OUT_DW-1:0] out_data_r, skid_data_r;
  logic              out_deg_r, skid_deg_r;
  logic              out_pop;

  assign out_pop = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_pop) skid_vld_r <= 1'b0;
    end else if (t_vld) begin
      if (!out_vld_r || out_pop) out_vld_r <= 1'b1;
      else skid_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_pop) begin
        out_data_r <= skid_data_r;
        out_deg_r  <= skid_deg_r;
      end
    end else if (t_vld) begin
      if (!out_vld_r || out_pop) begin
        out_data_r <= pd;
        out_deg_r  <= deg_t;
      end else begin
        skid_data_r <= pd;
        skid_deg_r  <= deg_t;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid entry filled without a stalled output");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_deg_r) |-> (out_data_r == '0))
    else $error("degenerate transaction carries nonzero vectors");
`endif
endmodule
`default_nettype wire

// File: tb/sv/obfv_checker.sv
// Scoreboard: predicts each basis from the accepted input and compares the outputs.
module obfv_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [obfv_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [47:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [obfv_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                          out_tuser,
  output int                            mismatches,
  output int                            pending,
  output int                            bases_checked
);
  import obfv_pkg::*;

  localparam int FRAC = 14;

  typedef longint vec3_t [3];
  typedef struct packed {
    logic [OUT_DW-1:0] vecs;
    logic              degen;
  } basis_t;

  basis_t            basis_q[$];
  logic [CFG_W-1:0]  threshold;

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Range-scale to [2^29, 2^30), floor length, rounded divide, saturate.
  function automatic bit normalise(input vec3_t v, output vec3_t u);
    logic [63:0] m [3];
    logic [63:0] mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (len >> 1)) / len;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic basis_t predict_basis(input logic [47:0] d, input logic [CFG_W-1:0] thr);
    vec3_t  v, n, w, s, c, t;
    longint one, dot;
    basis_t b;
    bit     ok;
    one = longint'(1) << FRAC;
    b = '0;
    for (int i = 0; i < 3; i++) v[i] = longint'($signed(d[16*i +: 16]));
    if (!normalise(v, n)) begin
      b.degen = 1'b1;
      return b;
    end
    // Helper axis: Y when the first vector leans strongly on X
    if (mag(n[0]) > 64'(thr)) begin
      dot = n[1];
      w[0] = -dot * n[0];
      w[1] = one * one - dot * n[1];
      w[2] = -dot * n[2];
    end else begin
      dot = n[0];
      w[0] = one * one - dot * n[0];
      w[1] = -dot * n[1];
      w[2] = -dot * n[2];
    end
    ok = normalise(w, s);
    c[0] = n[1] * s[2] - n[2] * s[1];
    c[1] = n[2] * s[0] - n[0] * s[2];
    c[2] = n[0] * s[1] - n[1] * s[0];
    ok = normalise(c, t);
    for (int i = 0; i < 3; i++) begin
      b.vecs[16*i +: 16]     = n[i][15:0];
      b.vecs[16*(3+i) +: 16] = s[i][15:0];
      b.vecs[16*(6+i) +: 16] = t[i][15:0];
    end
    return b;
  endfunction

  always @(posedge clk) begin
    basis_t exp_b;
    bit     bad;
    if (!rst_n) begin
      threshold <= THR_RESET;
      basis_q.delete();
      pending = 0;
      mismatches <= 0;
      bases_checked <= 0;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (in_tvalid && in_tready) basis_q.push_back(predict_basis(in_tdata, threshold));
      if (out_tvalid && out_tready) begin
        if (basis_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected output transaction: %h", out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          exp_b = basis_q.pop_front();
          bad = exp_b.degen !== out_tuser;
          for (int f = 0; f < OUT_FIELDS; f++)
            if (exp_b.vecs[16*f +: 16] !== out_tdata[16*f +: 16]) bad = 1;
          if (bad) begin
            if (mismatches < 10)
              $display("mismatch #%0d: expected %h/%b got %h/%b", bases_checked,
                       exp_b.vecs, exp_b.degen, out_tdata, out_tuser);
            mismatches <= mismatches + 1;
          end
          bases_checked <= bases_checked + 1;
        end
      end
      pending = basis_q.size();
    end
  end
endmodule

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus, output back-pressure and verdict.
module testbench;
  import obfv_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000; // idle cycles allowed
  localparam int DRAIN_CYCLES   = 250;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [47:0]         in_tdata = '0;  // in_x, in_y, in_z from bit 0 up
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;      // first xyz, second xyz, third xyz from bit 0 up
  logic                out_tuser;      // degenerate

  int mismatches, pending, bases_checked;
  int vectors_sent = 0;
  int idle_cycles = 0;
  int thresholds_run = 1;
  bit smooth_flow = 0;   // stretches where neither side idles

  always #5 clk = ~clk;

  orthonormal_basis_from_vector_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  obfv_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .mismatches(mismatches), .pending(pending), .bases_checked(bases_checked)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (smooth_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver back-pressure, same gap profile
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  // Watchdog: cycles with no transaction on either channel and no threshold write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d bases outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // One input transaction, then an optional gap. tvalid is only lowered for a gap.
  task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    int gap;
    in_tdata  <= {z, y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    vectors_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Threshold writes only with the pipeline drained; every item yields a result.
  task automatic set_threshold(input logic [CFG_W-1:0] thr);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    thresholds_run++;
  endtask

  // Extremes, axis-aligned and zero vectors; the unit X vector is the
  // parallel-helper case once the threshold reaches one.
  task automatic directed_vectors();
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0, 16'sd0);
    send_vector(16'sd32767, 16'sd0, 16'sd0);
    send_vector(16'h8000, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd0, -16'sd1);
    send_vector(16'sd0, 16'h8000, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd32767);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767);
    send_vector(16'sd32767, 16'h8000, 16'sd32767);
    send_vector(16'sd1, 16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1, -16'sd1);
    send_vector(16'sd9, 16'sd4, 16'sd0);     // |x| near 0.9
    send_vector(16'sd9, 16'sd0, -16'sd5);
    send_vector(16'sd1000, -16'sd1, 16'sd1);
    send_vector(16'h0000, 16'hFFFF, 16'h0001);
  endtask

  function automatic logic [15:0] rand_comp(input int scale);
    case (scale)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic random_vectors(input int count);
    logic [15:0] x, y, z;
    int kind;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) smooth_flow = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      x = rand_comp(kind % 3);
      y = rand_comp(kind % 3);
      z = rand_comp(kind % 3);
      case (kind)
        6: begin y = 16'($signed(y) >>> 4); z = 16'($signed(z) >>> 4); end // near X axis
        7: z = 16'h0;
        8: begin y = 16'h0; z = 16'h0; end
        9: if ($urandom_range(0, 7) == 0) begin x = 16'h0; y = 16'h0; z = 16'h0; end
        default: ;
      endcase
      send_vector(x, y, z);
    end
    smooth_flow = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_vectors();                  // reset threshold
    random_vectors(220);
    set_threshold(15'd0);                // always Y helper unless x is zero
    directed_vectors();
    random_vectors(220);
    set_threshold(15'd16384);            // X helper kept even for a unit X input
    directed_vectors();
    random_vectors(220);
    set_threshold(15'h7FFF);             // above one: Y helper never used
    random_vectors(220);
    set_threshold(CFG_W'($urandom_range(0, 16384)));
    random_vectors(220);
    set_threshold(THR_RESET);
    random_vectors(40);

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d vectors over %0d threshold settings, %0d bases compared",
             vectors_sent, thresholds_run, bases_checked);
    $display("random back-pressure on both channels, pipeline drained at each change");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d bases never produced", mismatches, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/obfv_pkg.sv
hdl/obfv_sqrt_cell.sv
hdl/obfv_div_cell.sv
hdl/obfv_norm.sv
hdl/orthonormal_basis_from_vector_top.sv
tb/sv/obfv_checker.sv
tb/sv/testbench.sv
